FILE: rtl/sfd_pkg.sv
// Shared constants, codes and controller/datapath interface structs for the
// scoreboard frame deframer. No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int SCORE_SIZE_DEF = 4096;
  localparam int MAX_BODY_DEF   = 256;

  // offset is kept as five decimal digits (BCD) plus its binary value
  localparam int OFFSET_W = 17;
  localparam int BCD_W    = 20;
  localparam logic [BCD_W-1:0] OFFSET_MOD = 20'd100000;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 112;

  localparam logic [7:0] BYTE_SYN   = 8'h16;
  localparam logic [7:0] BYTE_SOH   = 8'h01;
  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_EOT   = 8'h04;
  localparam logic [7:0] BYTE_ETB   = 8'h17;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_WRITTEN = 3'd1,
    EV_EMPTY   = 3'd2,
    EV_DROP    = 3'd3,
    EV_READ    = 3'd4
  } event_t;

  typedef enum logic [3:0] {
    ERR_NONE    = 4'd0,
    ERR_SOH     = 4'd1,
    ERR_STX     = 4'd2,
    ERR_CTRL    = 4'd3,
    ERR_OUTSIDE = 4'd4,
    ERR_DIGIT   = 4'd5,
    ERR_HEX     = 4'd6,
    ERR_END     = 4'd7,
    ERR_SUM     = 4'd8,
    ERR_STORE   = 4'd9,
    ERR_BODY    = 4'd10
  } error_t;

  typedef struct packed {
    logic feed;      // feed beat accepted: parse it
    logic rd_issue;  // read beat accepted: fetch store byte
    logic rd_out;    // read data ready: load output register
    logic copy;      // body copy cycle
    logic clear;     // store clearing cycle
  } sfd_cmd_t;

  typedef struct packed {
    logic clear_last;  // last store entry being cleared
    logic copy_go;     // current beat is an ETB that writes a non-empty body
    logic copy_last;   // all staging reads issued, last write in flight
    logic out_free;    // output register can take a result
  } sfd_sts_t;

  // weight of the digit that falls off the top of the five-digit offset
  function automatic logic [BCD_W-1:0] digit_weight(input logic [3:0] digit);
    digit_weight = OFFSET_MOD * BCD_W'(digit);
  endfunction

endpackage

FILE: rtl/sfd_ctrl.sv
// Sequencer for the deframer: store clear after reset, read, body copy.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tuser,
  input  sfd_pkg::sfd_sts_t sts,
  output sfd_pkg::sfd_cmd_t cmd
);
  import sfd_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_COPY} state_t;

  state_t state;
  logic   accept;

  assign s_tready = (state == ST_IDLE) && sts.out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.feed     = accept && (s_tuser == CMD_FEED);
    cmd.rd_issue = accept && (s_tuser == CMD_READ);
    cmd.rd_out   = (state == ST_READ);
    cmd.copy     = (state == ST_COPY);
    cmd.clear    = (state == ST_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sts.clear_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd.rd_issue) state <= ST_READ;
          else if (cmd.feed && sts.copy_go) state <= ST_COPY;
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        ST_COPY: begin
          if (sts.copy_last) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sfd_datapath.sv
// Frame parser registers, staging RAM, score store RAM, tallies and output
// register of the deframer. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_datapath #(
  parameter int SCORE_SIZE = sfd_pkg::SCORE_SIZE_DEF,
  parameter int MAX_BODY   = sfd_pkg::MAX_BODY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sfd_pkg::sfd_cmd_t                cmd,
  output sfd_pkg::sfd_sts_t                sts,
  input  logic [sfd_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sfd_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [2:0]                       m_tuser
);
  import sfd_pkg::*;

  localparam int AW = $clog2(SCORE_SIZE);
  localparam int SW = $clog2(MAX_BODY);
  localparam int LW = $clog2(MAX_BODY + 2);
  localparam int CW = ((OFFSET_W > LW) ? OFFSET_W : LW) + 1;

  typedef enum logic [2:0] {SEC_NONE, SEC_SYNC, SEC_HEAD, SEC_BODY, SEC_CHECK} section_t;
  typedef enum logic [1:0] {V_PENDING, V_EMPTY, V_ERROR} verdict_t;

  logic [7:0]  rx_byte;
  logic [11:0] read_addr;
  assign rx_byte   = s_tdata[7:0];
  assign read_addr = s_tdata[19:8];

  // frame state
  section_t              section, section_next;
  verdict_t              verdict, verdict_next;
  error_t                latched_error, err_next;
  logic [BCD_W-1:0]      offset_bcd, bcd_next;
  logic [OFFSET_W-1:0]   offset_value, offset_next;
  logic [7:0]            sum_calc, sum_calc_next;
  logic [7:0]            sum_rcvd, sum_rcvd_next;
  logic [LW-1:0]         body_len, body_len_next;
  logic [31:0]           frames_tally, frames_next;
  logic [31:0]           errors_tally, errors_next;
  logic [31:0]           packets_tally, packets_next;

  event_t                ev_next;
  error_t                code_next;
  logic                  copy_go;
  logic                  stg_we;
  logic                  is_ctrl, is_digit, is_hex_alpha;
  logic [3:0]            hex_val;
  logic [BCD_W-1:0]      off_x10, offset_step;
  logic [CW-1:0]         span;

  // memories
  logic [7:0]            staging [MAX_BODY];
  logic [7:0]            store   [SCORE_SIZE];
  logic [7:0]            stg_q;
  logic [7:0]            store_q;
  logic                  in_range_q;

  // copy / clear sequencing
  logic [OFFSET_W-1:0]   copy_base;
  logic [LW-1:0]         copy_len, copy_idx;
  logic                  copy_wr_pend;
  logic [AW-1:0]         copy_waddr;
  logic [AW-1:0]         clr_addr;
  logic                  store_we;
  logic [AW-1:0]         store_waddr;
  logic [7:0]            store_wdata;

  // output register
  event_t                out_event;
  error_t                out_error;
  logic [7:0]            out_rbyte;
  logic [31:0]           out_frames, out_errors, out_packets;

  assign is_ctrl      = (rx_byte < 8'h20) || rx_byte[7];
  assign is_digit     = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign is_hex_alpha = (rx_byte >= 8'h41) && (rx_byte <= 8'h46);
  assign hex_val      = is_digit ? rx_byte[3:0] : rx_byte[3:0] + 4'd9;

  // offset*10 + digit, minus the weight of the digit shifted out
  assign off_x10     = {offset_value, 3'b000} + {2'b00, offset_value, 1'b0};
  assign offset_step = off_x10 + BCD_W'(rx_byte[3:0]) - digit_weight(offset_bcd[19:16]);
  assign span        = CW'(offset_value) + CW'(body_len);

  always_comb begin
    section_next  = section;
    verdict_next  = verdict;
    err_next      = latched_error;
    bcd_next      = offset_bcd;
    offset_next   = offset_value;
    sum_calc_next = sum_calc;
    sum_rcvd_next = sum_rcvd;
    body_len_next = body_len;
    stg_we        = 1'b0;
    ev_next       = EV_NONE;
    code_next     = ERR_NONE;
    copy_go       = 1'b0;
    frames_next   = frames_tally;
    errors_next   = errors_tally;
    packets_next  = packets_tally;

    if (rx_byte == BYTE_SYN) begin
      section_next  = SEC_SYNC;
      verdict_next  = V_PENDING;
      err_next      = ERR_NONE;
      bcd_next      = '0;
      offset_next   = '0;
      sum_calc_next = '0;
      sum_rcvd_next = '0;
      body_len_next = '0;
    end else begin
      if (rx_byte == BYTE_ETB) begin
        // judge on the state before the ETB itself is parsed
        if (verdict == V_EMPTY) begin
          ev_next = EV_EMPTY;
        end else if (verdict == V_ERROR) begin
          ev_next   = EV_DROP;
          code_next = latched_error;
        end else if (section != SEC_CHECK) begin
          ev_next   = EV_DROP;
          code_next = ERR_END;
        end else if (sum_calc != sum_rcvd) begin
          ev_next   = EV_DROP;
          code_next = ERR_SUM;
        end else if (body_len > LW'(MAX_BODY)) begin
          ev_next   = EV_DROP;
          code_next = ERR_BODY;
        end else if (span > CW'(SCORE_SIZE)) begin
          ev_next   = EV_DROP;
          code_next = ERR_STORE;
        end else begin
          ev_next = EV_WRITTEN;
          copy_go = (body_len != '0);
        end
        if (ev_next == EV_DROP) errors_next = errors_tally + 32'd1;
        else frames_next = frames_tally + 32'd1;
      end

      if (verdict == V_PENDING) begin
        if (section != SEC_NONE && section != SEC_CHECK) sum_calc_next = sum_calc + rx_byte;
        if (is_ctrl) begin
          if (rx_byte == BYTE_SOH) begin
            if (section != SEC_SYNC) begin
              verdict_next = V_ERROR;
              err_next     = ERR_SOH;
            end else begin
              section_next = SEC_HEAD;
            end
          end else if (rx_byte == BYTE_STX) begin
            if (section != SEC_HEAD) begin
              verdict_next = V_ERROR;
              err_next     = ERR_STX;
            end else begin
              section_next  = SEC_BODY;
              body_len_next = '0;
            end
          end else if (rx_byte == BYTE_EOT) begin
            // EOT anywhere but the body closes a good empty frame
            if (section != SEC_BODY) verdict_next = V_EMPTY;
            else section_next = SEC_CHECK;
          end else begin
            verdict_next = V_ERROR;
            err_next     = ERR_CTRL;
          end
        end else begin
          case (section)
            SEC_NONE: begin
              verdict_next = V_ERROR;
              err_next     = ERR_OUTSIDE;
            end
            SEC_HEAD: begin
              if (is_digit) begin
                offset_next = offset_step[OFFSET_W-1:0];
                bcd_next    = {offset_bcd[15:0], rx_byte[3:0]};
              end else begin
                verdict_next = V_ERROR;
                err_next     = ERR_DIGIT;
              end
            end
            SEC_BODY: begin
              if (body_len < LW'(MAX_BODY)) begin
                stg_we        = 1'b1;
                body_len_next = body_len + LW'(1);
              end else begin
                body_len_next = LW'(MAX_BODY + 1);
              end
            end
            SEC_CHECK: begin
              if (is_digit || is_hex_alpha) begin
                sum_rcvd_next = {sum_rcvd[3:0], hex_val};
              end else begin
                verdict_next = V_ERROR;
                err_next     = ERR_HEX;
              end
            end
            default: ;
          endcase
        end
      end
    end

    if (s_tlast) begin
      packets_next  = packets_tally + 32'd1;
      section_next  = SEC_NONE;
      verdict_next  = V_PENDING;
      err_next      = ERR_NONE;
      bcd_next      = '0;
      offset_next   = '0;
      sum_calc_next = '0;
      sum_rcvd_next = '0;
      body_len_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section       <= SEC_NONE;
      verdict       <= V_PENDING;
      latched_error <= ERR_NONE;
      offset_bcd    <= '0;
      offset_value  <= '0;
      sum_calc      <= '0;
      sum_rcvd      <= '0;
      body_len      <= '0;
      frames_tally  <= '0;
      errors_tally  <= '0;
      packets_tally <= '0;
    end else if (cmd.feed) begin
      section       <= section_next;
      verdict       <= verdict_next;
      latched_error <= err_next;
      offset_bcd    <= bcd_next;
      offset_value  <= offset_next;
      sum_calc      <= sum_calc_next;
      sum_rcvd      <= sum_rcvd_next;
      body_len      <= body_len_next;
      frames_tally  <= frames_next;
      errors_tally  <= errors_next;
      packets_tally <= packets_next;
    end
  end

  // staging RAM: written while the body streams in, read during the copy
  always_ff @(posedge clk) begin
    if (cmd.feed && stg_we) staging[body_len[SW-1:0]] <= rx_byte;
    stg_q <= staging[copy_idx[SW-1:0]];
  end

  // copy sequencer: read staging at copy_idx, write the store in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_wr_pend <= 1'b0;
      clr_addr     <= '0;
    end else begin
      copy_wr_pend <= cmd.copy && (copy_idx != copy_len);
      if (cmd.clear) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed && copy_go) begin
      copy_base <= offset_value;
      copy_len  <= body_len;
      copy_idx  <= '0;
    end else if (cmd.copy && (copy_idx != copy_len)) begin
      copy_idx <= copy_idx + LW'(1);
    end
    copy_waddr <= AW'(CW'(copy_base) + CW'(copy_idx));
  end

  assign store_we    = cmd.clear || copy_wr_pend;
  assign store_waddr = cmd.clear ? clr_addr : copy_waddr;
  assign store_wdata = cmd.clear ? BYTE_SPACE : stg_q;

  always_ff @(posedge clk) begin
    if (store_we) store[store_waddr] <= store_wdata;
    if (cmd.rd_issue) begin
      store_q    <= store[AW'(read_addr)];
      in_range_q <= (17'(read_addr) < 17'(SCORE_SIZE));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.feed || cmd.rd_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.feed) begin
      out_event   <= ev_next;
      out_error   <= code_next;
      out_rbyte   <= 8'h00;
      out_frames  <= frames_next;
      out_errors  <= errors_next;
      out_packets <= packets_next;
    end else if (cmd.rd_out) begin
      out_event   <= EV_READ;
      out_error   <= ERR_NONE;
      out_rbyte   <= in_range_q ? store_q : BYTE_SPACE;
      out_frames  <= frames_tally;
      out_errors  <= errors_tally;
      out_packets <= packets_tally;
    end
  end

  assign m_tuser = out_event;
  assign m_tdata = {4'b0000, out_packets, out_errors, out_frames, out_rbyte, out_error};

  always_comb begin
    sts.clear_last = (clr_addr == AW'(SCORE_SIZE - 1));
    sts.copy_go    = copy_go;
    sts.copy_last  = (copy_idx == copy_len);
    sts.out_free   = !m_tvalid || m_tready;
  end

endmodule

FILE: rtl/scoreboard_frame_deframer.sv
// Top level of the scoreboard frame deframer: sequencer plus datapath.
// Depends on sfd_pkg, sfd_ctrl and sfd_datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser cmd, tlast datagram_last,
//          |     |                    | tdata {read_addr, rx_byte}
//  m_      | out | m_tvalid/m_tready  | tuser event_res, tdata {packet_count,
//          |     |                    | error_count, frame_count, read_byte, error_code}
//
// Sequencing: an ETB that writes a non-empty body starts a copy, in which the
//   staging RAM is read one byte per cycle into the store.
//   A read beat goes through the registered store read port.
// Reset: synchronous; afterward all SCORE_SIZE entries (4096 by default) of the
//   score store are filled with spaces, one entry per cycle, with s_tready low.
// Stalls: one result register; s_tready drops while it holds a beat not taken.
`timescale 1ns / 1ps

module scoreboard_frame_deframer #(
  parameter int SCORE_SIZE = sfd_pkg::SCORE_SIZE_DEF,
  parameter int MAX_BODY   = sfd_pkg::MAX_BODY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [7:0] rx_byte, [19:8] read_addr, [23:20] zero
  input  logic [sfd_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tlast,
  // [0] cmd
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] error_code, [11:4] read_byte, [43:12] frame_count,
  // [75:44] error_count, [107:76] packet_count, [111:108] zero
  output logic [sfd_pkg::OUT_DATA_W-1:0]  m_tdata,
  // [2:0] event_res
  output logic [2:0]                      m_tuser
);
  import sfd_pkg::*;

  sfd_cmd_t cmd;
  sfd_sts_t sts;

  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfd_datapath #(
    .SCORE_SIZE (SCORE_SIZE),
    .MAX_BODY   (MAX_BODY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // never take a beat while a result is blocked
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result register blocked");

  // a feed beat yields its result on the next cycle
  a_feed_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_FEED) |=> (m_tvalid && m_tuser != EV_READ))
    else $error("feed beat without result");

  // a read beat yields read data once the store read and the output register have loaded
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_READ) |=> ##1 (m_tvalid && m_tuser == EV_READ))
    else $error("read beat without read data");

endmodule
